[src/c2d_pkg.sv]
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and constants of the 3x3 convolution block
// Kernel geometry, register codes, reset values and the control groups that
// run between the top level and the multiply cells.
// ----------------------------------------------------------------------------
package c2d_pkg;

  // kernel geometry and field widths
  localparam int KERNEL_SIZE    = 3;
  localparam int COEF_BITS      = 16;
  localparam int CFG_BITS       = 48;
  localparam int CFG_INDEX_BITS = 3;
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 16;
  localparam int OUT_BITS       = 32;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } c2d_reg_t;

  // reset values of the configuration registers
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET         = 11'd1024;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET        = 16'd1024;
  localparam logic [CFG_BITS-1:0]    KERNEL_TOP_RESET    = 48'h0000_0000_0000;
  localparam logic [CFG_BITS-1:0]    KERNEL_MIDDLE_RESET = 48'h0000_4000_0000;
  localparam logic [CFG_BITS-1:0]    KERNEL_BOTTOM_RESET = 48'h0000_0000_0000;

  // saturation limits of the result
  localparam logic signed [OUT_BITS-1:0] OUT_MAX = 32'sh7fff_ffff;
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = 32'sh8000_0000;

  // per-cycle step enables handed to every cell
  typedef struct packed {
    logic shift;  // window moves one column
    logic mul;    // products of the held column are taken
    logic add;    // column sum of the products is taken
  } c2d_step_t;

  // position flags that travel with an item down the pipeline
  typedef struct packed {
    logic                   emit;
    logic                   last;
    logic [KERNEL_SIZE-1:0] row_ok;
    logic [KERNEL_SIZE-1:0] col_ok;
  } c2d_tag_t;

endpackage

[src/c2d_linebuf.sv]
// ----------------------------------------------------------------------------
// c2d_linebuf: two-row line store with one read and one write per cycle
// Keeps the two previous rows as one word per column. The word is read when
// an item is accepted and written back, shifted by one row, when the item
// leaves the first stage. A same-column write that lands on the read cycle
// is forwarded.
// ----------------------------------------------------------------------------
module c2d_linebuf import c2d_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic signed [PIXEL_BITS-1:0] pix_in,
  input  logic                         wr_en,
  output logic signed [PIXEL_BITS-1:0] fresh [KERNEL_SIZE]
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DW = 2 * PIXEL_BITS;

  logic [DW-1:0]         mem [MAX_WIDTH];
  logic [DW-1:0]         rd_data;
  logic [DW-1:0]         byp_data;
  logic                  byp_hit;
  logic [AW-1:0]         addr_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [DW-1:0]         word;
  logic [DW-1:0]         wr_data;

  // upper row in the high half, lower row in the low half
  assign word    = byp_hit ? byp_data : rd_data;
  assign wr_data = {word[PIXEL_BITS-1:0], pix_q};

  assign fresh[0] = word[DW-1:PIXEL_BITS];
  assign fresh[1] = word[PIXEL_BITS-1:0];
  assign fresh[2] = pix_q;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // item held in the first stage, forwarding of a same-column write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q   <= rd_addr;
      pix_q    <= pix_in;
      byp_hit  <= wr_en && (addr_q == rd_addr);
      byp_data <= wr_data;
    end
  end

endmodule

[src/c2d_cell.sv]
// ----------------------------------------------------------------------------
// c2d_cell: one window column with its three multipliers
// Holds a column of three pixels, passes it to the left neighbor on a shift,
// multiplies it by its kernel column and adds the three products.
// ----------------------------------------------------------------------------
module c2d_cell import c2d_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                     clk,
  input  c2d_step_t                                step,
  input  logic [KERNEL_SIZE-1:0]                   keep,
  input  logic signed [COEF_BITS-1:0]              coef    [KERNEL_SIZE],
  input  logic signed [PIXEL_BITS-1:0]             pix_in  [KERNEL_SIZE],
  output logic signed [PIXEL_BITS-1:0]             pix_out [KERNEL_SIZE],
  output logic signed [PIXEL_BITS+COEF_BITS+1:0]   col_sum
);

  localparam int PROD_W = PIXEL_BITS + COEF_BITS;
  localparam int COL_W  = PROD_W + 2;

  logic signed [PIXEL_BITS-1:0] pix  [KERNEL_SIZE];
  logic signed [PROD_W-1:0]     prod [KERNEL_SIZE];

  assign pix_out = pix;

  // column shift, products, column sum
  always_ff @(posedge clk) begin
    if (step.shift) begin
      pix <= pix_in;
    end
    if (step.mul) begin
      for (int y = 0; y < KERNEL_SIZE; y++) begin
        // signed product, masked neighbors give zero
        if (keep[y]) begin
          prod[y] <= pix[y] * coef[y];
        end else begin
          prod[y] <= '0;
        end
      end
    end
    if (step.add) begin
      col_sum <= COL_W'(prod[0]) + COL_W'(prod[1]) + COL_W'(prod[2]);
    end
  end

endmodule

[src/conv2d_3x3_zero_padded.sv]
// ----------------------------------------------------------------------------
// conv2d_3x3_zero_padded: streaming 3x3 convolution with zero padding
// Line store, three-cell window chain with nine multipliers, adder, output
// register.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock while the output does not stall, and returns
// at most one result per item. Pixels come in raster order; the result for a
// pixel leaves with the item that arrives one row plus one pixel later, so
// after each frame send image_width+1 flush items (command = 1). A result
// passes the line store read, window shift, products, column sums and output
// register in turn. The rate is set by the single read and single write per
// cycle of the line store and the nine multipliers spread over three window
// cells. Neighbors outside the image are masked by position, so the line store
// needs no clearing after reset. Writing image_width or image_height restarts
// the frame; write the registers only while the block is idle.
// ----------------------------------------------------------------------------
module conv2d_3x3_zero_padded import c2d_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic signed [PIXEL_BITS-1:0] pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_BITS-1:0]   out_pixel,
  output logic                         out_last
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int EW     = ($clog2(MAX_WIDTH + 1) > WIDTH_BITS) ?
                          $clog2(MAX_WIDTH + 1) : WIDTH_BITS;
  localparam int RW     = HEIGHT_BITS + 1;
  localparam int PROD_W = PIXEL_BITS + COEF_BITS;
  localparam int COL_W  = PROD_W + 2;
  localparam int SUM_W  = (PROD_W + 4 > OUT_BITS + 1) ? PROD_W + 4 : OUT_BITS + 1;

  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-OUT_BITS+1){1'b0}},
                                                {(OUT_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-OUT_BITS+1){1'b1}},
                                                {(OUT_BITS-1){1'b0}}};

  // configuration registers
  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic [CFG_BITS-1:0]    kernel_row [KERNEL_SIZE];
  logic                   cfg_restart;

  // position counters
  logic [AW-1:0]          in_column,  in_column_next;
  logic [RW-1:0]          in_row,     in_row_next;
  logic [AW-1:0]          out_column, out_column_next;
  logic [HEIGHT_BITS-1:0] out_row,    out_row_next;

  logic [EW-1:0]          eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;
  logic                   col_wrap, row_past, out_col_end, out_row_end;
  logic signed [PIXEL_BITS-1:0] pix0;
  c2d_tag_t               tag0, tag1, tag2, tag3, tag4;
  logic                   accept;

  // pipeline control
  logic                   v1, v2, v3, v4;
  logic                   adv1, adv2, adv3, adv4;
  logic                   free1, free2, free3, free4, free_out;
  c2d_step_t              step;

  // datapath
  logic signed [PIXEL_BITS-1:0] link [1:KERNEL_SIZE][KERNEL_SIZE];
  logic signed [COEF_BITS-1:0]  coef [KERNEL_SIZE][KERNEL_SIZE];
  logic [KERNEL_SIZE-1:0]       keep [KERNEL_SIZE];
  logic signed [COL_W-1:0]      col_sum [KERNEL_SIZE];
  logic signed [SUM_W-1:0]      sum;
  logic signed [OUT_BITS-1:0]   sat;

  // configuration writes
  assign cfg_restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                                  cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
      kernel_row[0] <= KERNEL_TOP_RESET;
      kernel_row[1] <= KERNEL_MIDDLE_RESET;
      kernel_row[2] <= KERNEL_BOTTOM_RESET;
    end else if (cfg_we) begin
      case (c2d_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[HEIGHT_BITS-1:0];
        REG_KERNEL_TOP:    kernel_row[0] <= cfg_data;
        REG_KERNEL_MIDDLE: kernel_row[1] <= cfg_data;
        REG_KERNEL_BOTTOM: kernel_row[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (image_width == '0) begin
      eff_w = EW'(1);
    end else if (EW'(image_width) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(image_width);
    end
    eff_h = (image_height == '0) ? HEIGHT_BITS'(1) : image_height;
  end

  // position of the incoming item and of the result it releases
  always_comb begin
    col_wrap    = (EW'(in_column) + EW'(1)) >= eff_w;
    row_past    = in_row >= RW'(eff_h);
    out_col_end = (EW'(out_column) + EW'(1)) >= eff_w;
    out_row_end = (RW'(out_row) + RW'(1)) >= RW'(eff_h);
    pix0        = (command || row_past) ? '0 : pixel;

    tag0.emit   = (in_row != '0) && ((in_column != '0) || (in_row >= RW'(2)));
    tag0.last   = out_row_end && out_col_end;
    tag0.row_ok = {!out_row_end, 1'b1, out_row != '0};
    tag0.col_ok = {!out_col_end && (in_column != '0), 1'b1, out_column != '0};

    in_column_next  = col_wrap ? '0 : in_column + AW'(1);
    in_row_next     = col_wrap ? in_row + RW'(1) : in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (tag0.emit) begin
      if (tag0.last) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
      end else begin
        out_column_next = out_col_end ? '0 : out_column + AW'(1);
        out_row_next    = out_col_end ? out_row + HEIGHT_BITS'(1) : out_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (accept) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // stage advance, each stage moves when the next one frees up; an item with no result leaves the last stage freely
  assign free_out = !out_valid || out_ready;
  assign adv4     = v4 && (!tag4.emit || free_out);
  assign free4    = !v4 || adv4;
  assign adv3     = v3 && free4;
  assign free3    = !v3 || adv3;
  assign adv2     = v2 && free3;
  assign free2    = !v2 || adv2;
  assign adv1     = v1 && free2;
  assign free1    = !v1 || adv1;
  assign in_ready = free1;
  assign accept   = in_valid && in_ready;

  assign step.shift = adv1;
  assign step.mul   = adv2;
  assign step.add   = adv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free1) v1 <= accept;
      if (free2) v2 <= adv1;
      if (free3) v3 <= adv2;
      if (free4) v4 <= adv3;
      if (adv4 && tag4.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item flags down the pipeline
  always_ff @(posedge clk) begin
    if (accept) tag1 <= tag0;
    if (adv1)   tag2 <= tag1;
    if (adv2)   tag3 <= tag2;
    if (adv3)   tag4 <= tag3;
  end

  // line store feeds the head of the window chain
  c2d_linebuf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_column),
    .pix_in  (pix0),
    .wr_en   (adv1),
    .fresh   (link[KERNEL_SIZE])
  );

  // flipped kernel column and position mask of each cell
  always_comb begin
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      for (int y = 0; y < KERNEL_SIZE; y++) begin
        coef[k][y] = kernel_row[KERNEL_SIZE-1-y][COEF_BITS*(KERNEL_SIZE-1-k) +: COEF_BITS];
        keep[k][y] = tag2.row_ok[y] & tag2.col_ok[k];
      end
    end
  end

  // window chain, newest column at the highest cell
  for (genvar k = 0; k < KERNEL_SIZE; k++) begin : g_cell
    if (k == 0) begin : g_tail
      c2d_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell (
        .clk     (clk),
        .step    (step),
        .keep    (keep[k]),
        .coef    (coef[k]),
        .pix_in  (link[k+1]),
        .pix_out (),
        .col_sum (col_sum[k])
      );
    end else begin : g_body
      c2d_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell (
        .clk     (clk),
        .step    (step),
        .keep    (keep[k]),
        .coef    (coef[k]),
        .pix_in  (link[k+1]),
        .pix_out (link[k]),
        .col_sum (col_sum[k])
      );
    end
  end

  // final sum and saturation
  always_comb begin
    sum = SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);
    if (sum > SAT_HI) begin
      sat = OUT_MAX;
    end else if (sum < SAT_LO) begin
      sat = OUT_MIN;
    end else begin
      sat = sum[OUT_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv4 && tag4.emit) begin
      out_pixel <= sat;
      out_last  <= tag4.last;
    end
  end

  // checks
  a_in_col_range: assert property (@(posedge clk) disable iff (rst)
    EW'(in_column) < eff_w)
    else $error("input column beyond row width");

  a_out_col_range: assert property (@(posedge clk) disable iff (rst)
    EW'(out_column) < eff_w)
    else $error("output column beyond row width");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    accept && tag0.emit && tag0.last |=>
      (in_column == '0) && (in_row == '0) && (out_column == '0) && (out_row == '0))
    else $error("counters not cleared after last result of frame");

  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted item missing from first stage");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    adv4 && tag4.emit |=> out_valid)
    else $error("result lost at output register");

endmodule
